### rtl/core/rar_pkg.sv
// Shared types and constants for the rational arithmetic and reduction block.
package rar_pkg;

  // Default width of one input numerator or denominator.
  localparam int WIDTH_DEF = 16;

  // Width of the operation selector.
  localparam int OP_BITS = 2;

  // Arithmetic operation carried with each input word.
  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DEN,
    ST_MUL_T1,
    ST_MUL_T2,
    ST_COMBINE,
    ST_EUC_INIT,
    ST_REM_START,
    ST_REM_WAIT,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_DIVD_START,
    ST_DIVD_WAIT,
    ST_FINISH
  } state_t;

  // Which cross product the shared multiplier forms.
  typedef enum logic [1:0] {
    MS_DEN,
    MS_T1,
    MS_T2
  } mul_sel_t;

  // Which operand pair the shared divider receives.
  typedef enum logic [1:0] {
    DS_REM,
    DS_NUM,
    DS_DEN
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     combine;
    logic     euc_init;
    logic     div_start;
    div_sel_t div_sel;
    logic     rem_update;
    logic     store_num;
    logic     store_den;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flag;
    logic pq_zero;
    logic div_busy;
    logic div_done;
    logic rem_zero;
  } dp_sts_t;

endpackage

### rtl/core/rar_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rar_div #(
  parameter int BITS = 2 * rar_pkg::WIDTH_DEF + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [BITS-1:0] dividend,
  input  logic signed [BITS-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic signed [BITS-1:0] quo,
  output logic signed [BITS-1:0] rem
);
  import rar_pkg::*;

  localparam int CNT_W = $clog2(BITS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             negq_r;
  logic             negr_r;
  logic [BITS-1:0]  dvsr_r;
  logic [BITS:0]    part_r;
  logic [BITS-1:0]  quo_r;
  logic [BITS-1:0]  quo_out_r;
  logic [BITS-1:0]  rem_out_r;

  logic [BITS-1:0]  a_mag;
  logic [BITS-1:0]  b_mag;
  logic [BITS:0]    shifted;
  logic [BITS:0]    diff;
  logic             fits;

  // Magnitudes of the operands at start.
  assign a_mag = dividend[BITS-1] ? (~dividend + 1'b1) : dividend;
  assign b_mag = divisor[BITS-1] ? (~divisor + 1'b1) : divisor;

  // One restoring step: bring in the next dividend bit and try the subtract.
  assign shifted = {part_r[BITS-1:0], quo_r[BITS-1]};
  assign diff    = shifted - {1'b0, dvsr_r};
  assign fits    = ~diff[BITS];

  // Sequencing of the bit loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(BITS);
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_r  <= cnt_r - 1'b1;
    end else if (busy_r) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // Partial remainder, quotient and the final sign fix.
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr_r <= b_mag;
      part_r <= '0;
      quo_r  <= a_mag;
      negq_r <= dividend[BITS-1] ^ divisor[BITS-1];
      negr_r <= dividend[BITS-1];
    end else if (busy_r && (cnt_r != '0)) begin
      part_r <= fits ? diff : shifted;
      quo_r  <= {quo_r[BITS-2:0], fits};
    end else if (busy_r) begin
      quo_out_r <= negq_r ? (~quo_r + 1'b1) : quo_r;
      rem_out_r <= negr_r ? (~part_r[BITS-1:0] + 1'b1) : part_r[BITS-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = $signed(quo_out_r);
  assign rem  = $signed(rem_out_r);

`ifndef SYNTHESIS
  // A result is only announced at the end of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding busy phase");
`endif

endmodule

### rtl/core/rar_dp.sv
// Datapath: operand registers, shared multiplier, Euclid registers and divider.
module rar_dp #(
  parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rar_pkg::op_t              in_op,
  input  logic signed [WIDTH-1:0]   in_a_num,
  input  logic signed [WIDTH-1:0]   in_a_den,
  input  logic signed [WIDTH-1:0]   in_b_num,
  input  logic signed [WIDTH-1:0]   in_b_den,
  input  rar_pkg::dp_cmd_t          cmd,
  output rar_pkg::dp_sts_t          sts,
  output logic signed [2*WIDTH:0]   res_num,
  output logic signed [2*WIDTH-1:0] res_den,
  output logic                      div_by_zero
);
  import rar_pkg::*;

  localparam int NUM_W = 2 * WIDTH + 1;
  localparam int DEN_W = 2 * WIDTH;

  op_t                     op_r;
  logic signed [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic                    flag_r;
  logic signed [DEN_W-1:0] den_r, t1_r, t2_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [NUM_W-1:0] p_r, q_r, f_r;
  logic signed [NUM_W-1:0] rnum_r;
  logic signed [DEN_W-1:0] rden_r;
  logic signed [NUM_W-1:0] onum_r;
  logic signed [DEN_W-1:0] oden_r;
  logic                    oflag_r;

  logic signed [WIDTH-1:0] mul_a, mul_b;
  logic signed [DEN_W-1:0] mul_ax, mul_bx, prod;
  logic signed [NUM_W-1:0] t1_x, t2_x, den_x, comb_num;
  logic signed [NUM_W-1:0] div_a, div_b, div_quo, div_rem;
  logic                    div_busy, div_done;

  // Input capture; a zero denominator counts as one.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_op;
      an_r   <= in_a_num;
      ad_r   <= (in_a_den == '0) ? WIDTH'(1) : in_a_den;
      bn_r   <= in_b_num;
      bd_r   <= (in_b_den == '0) ? WIDTH'(1) : in_b_den;
      flag_r <= (in_op == OP_DIV) && (in_b_num == '0);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = ad_r;
    mul_b = bd_r;
    unique case (cmd.mul_sel)
      MS_DEN: begin
        mul_a = ad_r;
        mul_b = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      MS_T1: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      MS_T2: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  assign mul_ax = {{WIDTH{mul_a[WIDTH-1]}}, mul_a};
  assign mul_bx = {{WIDTH{mul_b[WIDTH-1]}}, mul_b};
  assign prod   = mul_ax * mul_bx;

  // Cross products land in their own registers.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_DEN:  den_r <= prod;
        MS_T1:   t1_r  <= prod;
        default: t2_r  <= prod;
      endcase
    end
  end

  // Numerator from the cross products.
  assign t1_x  = {t1_r[DEN_W-1], t1_r};
  assign t2_x  = {t2_r[DEN_W-1], t2_r};
  assign den_x = {den_r[DEN_W-1], den_r};

  always_comb begin
    case (op_r)
      OP_ADD:  comb_num = t1_x + t2_x;
      OP_SUB:  comb_num = t1_x - t2_x;
      default: comb_num = t1_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      num_r <= comb_num;
    end
  end

  // Euclid pair (p, q) and the common factor f.
  always_ff @(posedge clk) begin
    if (cmd.euc_init) begin
      p_r <= den_x;
      q_r <= num_r;
      f_r <= NUM_W'(1);
    end else if (cmd.rem_update) begin
      if (div_rem == '0) begin
        f_r <= q_r;
      end else begin
        p_r <= q_r;
        q_r <= div_rem;
      end
    end
  end

  // Operand pair for the shared divider.
  always_comb begin
    div_a = p_r;
    div_b = q_r;
    unique case (cmd.div_sel)
      DS_REM: begin
        div_a = p_r;
        div_b = q_r;
      end
      DS_NUM: begin
        div_a = num_r;
        div_b = f_r;
      end
      DS_DEN: begin
        div_a = den_x;
        div_b = f_r;
      end
      default: begin
        div_a = p_r;
        div_b = q_r;
      end
    endcase
  end

  rar_div #(
    .BITS (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Reduced parts.
  always_ff @(posedge clk) begin
    if (cmd.store_num) begin
      rnum_r <= div_quo;
    end
    if (cmd.store_den) begin
      rden_r <= div_quo[DEN_W-1:0];
    end
  end

  // Output word; a divide by a zero fraction gives 0/1.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      onum_r  <= flag_r ? '0 : rnum_r;
      oden_r  <= (flag_r || (rden_r == '0)) ? DEN_W'(1) : rden_r;
      oflag_r <= flag_r;
    end
  end

  assign sts.flag     = flag_r;
  assign sts.pq_zero  = (den_r == '0) || (num_r == '0);
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.rem_zero = (div_rem == '0);

  assign res_num     = onum_r;
  assign res_den     = oden_r;
  assign div_by_zero = oflag_r;

endmodule

### rtl/core/rar_ctrl.sv
// Controller: sequences products, the Euclid loop and the final divisions.
module rar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rar_pkg::dp_sts_t  sts,
  output rar_pkg::dp_cmd_t  cmd
);
  import rar_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register can take a new word when empty or being drained.
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_tvalid) state_nxt = ST_MUL_DEN;
      ST_MUL_DEN:    state_nxt = ST_MUL_T1;
      ST_MUL_T1:     state_nxt = ST_MUL_T2;
      ST_MUL_T2:     state_nxt = ST_COMBINE;
      ST_COMBINE:    state_nxt = ST_EUC_INIT;
      ST_EUC_INIT: begin
        if (sts.flag) begin
          state_nxt = ST_FINISH;
        end else if (sts.pq_zero) begin
          state_nxt = ST_DIVN_START;
        end else begin
          state_nxt = ST_REM_START;
        end
      end
      ST_REM_START:  state_nxt = ST_REM_WAIT;
      ST_REM_WAIT: begin
        if (sts.div_done) begin
          state_nxt = sts.rem_zero ? ST_DIVN_START : ST_REM_START;
        end
      end
      ST_DIVN_START: state_nxt = ST_DIVN_WAIT;
      ST_DIVN_WAIT:  if (sts.div_done) state_nxt = ST_DIVD_START;
      ST_DIVD_START: state_nxt = ST_DIVD_WAIT;
      ST_DIVD_WAIT:  if (sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH:     if (slot_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MS_DEN;
    cmd.div_sel   = DS_REM;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_MUL_DEN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DEN;
      end
      ST_MUL_T1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_T1;
      end
      ST_MUL_T2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_T2;
      end
      ST_COMBINE:    cmd.combine = 1'b1;
      ST_EUC_INIT:   cmd.euc_init = 1'b1;
      ST_REM_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_REM;
      end
      ST_REM_WAIT:   cmd.rem_update = sts.div_done;
      ST_DIVN_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_NUM;
      end
      ST_DIVN_WAIT:  cmd.store_num = sts.div_done;
      ST_DIVD_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DEN;
      end
      ST_DIVD_WAIT:  cmd.store_den = sts.div_done;
      ST_FINISH: begin
        cmd.out_load = slot_free;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  // The divider is never restarted while a division runs.
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A new result never overwrites a word still waiting on the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output word overwritten before it was taken");

  // An accepted word cannot produce a result in the very next cycle.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_valid_r) |=> !out_valid_r)
    else $error("result appeared too early after accept");
`endif

endmodule

### rtl/core/rational_arith_reduce.sv
// Top level: fraction add, subtract, multiply or divide with reduction by Euclid's loop.
//
// Each input word carries two fractions and an operation. The block forms the
// cross products on one shared multiplier, then finds a common factor by
// Euclid's truncating remainder loop and divides both parts by it. All
// remainders and both final divisions run on one shared bit-serial divider
// of 2*WIDTH+1 bits. A divide by a zero fraction skips the remainder loop
// and both divisions. One item is worked on at a time; the finished word
// sits in an output register, so the next input word is taken while it
// waits. The factor may be negative, in which case both result signs flip;
// the denominator is not normalized to be positive.
module rational_arith_reduce #(
  parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // in_tdata fields, low to high: a_num, a_den, b_num, b_den
  input  logic [((4 * WIDTH + 7) / 8) * 8 - 1:0]   in_tdata,
  // in_tuser fields: operation
  input  logic [rar_pkg::OP_BITS-1:0]              in_tuser,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // out_tdata fields, low to high: res_num, res_den, zero fill
  output logic [((4 * WIDTH + 8) / 8) * 8 - 1:0]   out_tdata,
  // out_tuser fields: div_by_zero
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready
);
  import rar_pkg::*;

  localparam int NUM_W       = 2 * WIDTH + 1;
  localparam int DEN_W       = 2 * WIDTH;
  localparam int OUT_TDATA_W = ((4 * WIDTH + 8) / 8) * 8;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic signed [NUM_W-1:0] res_num;
  logic signed [DEN_W-1:0] res_den;
  logic                    div_by_zero;

  rar_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rar_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (op_t'(in_tuser)),
    .in_a_num    ($signed(in_tdata[WIDTH-1:0])),
    .in_a_den    ($signed(in_tdata[2*WIDTH-1:WIDTH])),
    .in_b_num    ($signed(in_tdata[3*WIDTH-1:2*WIDTH])),
    .in_b_den    ($signed(in_tdata[4*WIDTH-1:3*WIDTH])),
    .cmd         (cmd),
    .sts         (sts),
    .res_num     (res_num),
    .res_den     (res_den),
    .div_by_zero (div_by_zero)
  );

  // Output word packing.
  assign out_tdata = OUT_TDATA_W'({res_den, res_num});
  assign out_tuser = div_by_zero;

`ifndef SYNTHESIS
  // A delivered denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_den != '0))
    else $error("result denominator is zero");
`endif

endmodule

### tb/rar_checker.sv
// Checker for the rational arithmetic block: predicts each reduced fraction and compares it.
`timescale 1ns / 100ps

module rar_checker #(
  parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata fields, low to high: a_num, a_den, b_num, b_den
  input  logic [((4 * WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser fields: operation
  input  logic [rar_pkg::OP_BITS-1:0]            in_tuser,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  // out_tdata fields, low to high: res_num, res_den, zero fill
  input  logic [((4 * WIDTH + 8) / 8) * 8 - 1:0] out_tdata,
  // out_tuser fields: div_by_zero
  input  logic                                   out_tuser,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     checked_count,
  output int                                     flagged_count
);
  import rar_pkg::*;

  // One reduced fraction as the block reports it.
  typedef struct packed {
    logic signed [2*WIDTH:0]   num;
    logic signed [2*WIDTH-1:0] den;
    logic                      flag;
  } fraction_t;

  // Fractions still owed by the block, oldest first.
  fraction_t owed_fractions[$];

  // Apply the operation, then divide both parts by the factor that the
  // truncating Euclid loop on (denominator, numerator) finds.
  function automatic fraction_t reduce_fraction(input op_t op,
                                                input logic signed [WIDTH-1:0] an_i,
                                                input logic signed [WIDTH-1:0] ad_i,
                                                input logic signed [WIDTH-1:0] bn_i,
                                                input logic signed [WIDTH-1:0] bd_i);
    longint an, ad, bn, bd, num, den, p, q, r, f;
    fraction_t res;
    an = an_i;
    ad = ad_i;
    bn = bn_i;
    bd = bd_i;
    res.flag = 1'b0;
    // A zero denominator on either input counts as one.
    if (ad == 0) ad = 1;
    if (bd == 0) bd = 1;
    case (op)
      OP_ADD: begin
        den = ad * bd;
        num = an * bd + bn * ad;
      end
      OP_SUB: begin
        den = ad * bd;
        num = an * bd - bn * ad;
      end
      OP_MUL: begin
        den = ad * bd;
        num = an * bn;
      end
      default: begin
        if (bn == 0) begin
          num = 0;
          den = 1;
          res.flag = 1'b1;
        end else begin
          den = ad * bn;
          num = an * bd;
        end
      end
    endcase
    if (!res.flag) begin
      // The factor is one when either part is zero; it may come out negative.
      f = 1;
      if (den != 0 && num != 0) begin
        p = den;
        q = num;
        while (p % q != 0) begin
          r = p % q;
          p = q;
          q = r;
        end
        f = q;
      end
      num = num / f;
      den = den / f;
      if (den == 0) den = 1;
    end
    res.num = num[2*WIDTH:0];
    res.den = den[2*WIDTH-1:0];
    return res;
  endfunction

  // Retire result words against the oldest prediction, then queue new ones.
  always @(posedge clk) begin : watch
    fraction_t got;
    fraction_t want;
    int errs;
    int seen;
    int zeros;
    errs  = 0;
    seen  = 0;
    zeros = 0;
    if (!rst_n) begin
      owed_fractions.delete();
      fail_count    <= 0;
      pending       <= 0;
      checked_count <= 0;
      flagged_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.num  = out_tdata[2*WIDTH:0];
        got.den  = out_tdata[4*WIDTH:2*WIDTH+1];
        got.flag = out_tuser;
        if (owed_fractions.size() == 0) begin
          $error("result word with no prediction waiting: num %0d den %0d flag %0d",
                 $signed(got.num), $signed(got.den), got.flag);
          errs++;
        end else begin
          want = owed_fractions.pop_front();
          seen = 1;
          if (got.flag) zeros = 1;
          if (got.num !== want.num) begin
            $error("res_num mismatch: expected %0d, actual %0d",
                   $signed(want.num), $signed(got.num));
            errs++;
          end
          if (got.den !== want.den) begin
            $error("res_den mismatch: expected %0d, actual %0d",
                   $signed(want.den), $signed(got.den));
            errs++;
          end
          if (got.flag !== want.flag) begin
            $error("div_by_zero mismatch: expected %0d, actual %0d", want.flag, got.flag);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        owed_fractions.push_back(reduce_fraction(op_t'(in_tuser),
                                                 in_tdata[WIDTH-1:0],
                                                 in_tdata[2*WIDTH-1:WIDTH],
                                                 in_tdata[3*WIDTH-1:2*WIDTH],
                                                 in_tdata[4*WIDTH-1:3*WIDTH]));
      end
      fail_count    <= fail_count + errs;
      checked_count <= checked_count + seen;
      flagged_count <= flagged_count + zeros;
      pending       <= owed_fractions.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, fraction stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps

module testbench;
  import rar_pkg::*;

  localparam int WIDTH    = rar_pkg::WIDTH_DEF;
  localparam int IN_W     = ((4 * WIDTH + 7) / 8) * 8;
  localparam int OUT_W    = ((4 * WIDTH + 8) / 8) * 8;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 117;

  typedef logic [WIDTH-1:0] part_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic [OP_BITS-1:0] in_tuser = OP_ADD;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  int fail_count;
  int pending;
  int checked_count;
  int flagged_count;
  int send_idle  = 0;
  int recv_idle  = 0;
  int stall_cycles = 0;
  int words_per_op[4] = '{0, 0, 0, 0};

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rational_arith_reduce #(.WIDTH(WIDTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  rar_checker #(.WIDTH(WIDTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .flagged_count (flagged_count)
  );

  // Result side: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one word and hold it until it is taken. Valid stays high after the
  // handshake so that a back-to-back word needs no second assignment.
  task automatic send_word(input op_t op, input part_t an, input part_t ad,
                           input part_t bn, input part_t bd);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tdata  <= IN_W'({bd, bn, ad, an});
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_per_op[int'(op)]++;
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random word: full-range values, small values, values with a shared
  // factor, or corner values, with a share of divides by a zero fraction.
  task automatic send_random();
    op_t   op;
    int    mode;
    int    k;
    part_t v[4];
    op   = op_t'($urandom_range(3));
    mode = $urandom_range(9);
    k    = $urandom_range(60, 1);
    for (int i = 0; i < 4; i++) begin
      if (mode < 4) begin
        v[i] = part_t'($urandom);
      end else if (mode < 7) begin
        v[i] = part_t'(int'($urandom_range(24)) - 12);
      end else if (mode < 9) begin
        v[i] = part_t'((int'($urandom_range(40)) - 20) * k);
      end else begin
        case ($urandom_range(4))
          0: v[i] = {1'b1, {(WIDTH-1){1'b0}}};
          1: v[i] = {1'b0, {(WIDTH-1){1'b1}}};
          2: v[i] = '0;
          3: v[i] = part_t'(1);
          default: v[i] = '1;
        endcase
      end
    end
    if (op == OP_DIV && $urandom_range(9) == 0) v[2] = '0;
    send_word(op, v[0], v[1], v[2], v[3]);
  endtask

  // Stimulus and verdict.
  initial begin
    part_t pmax;
    part_t nmax;
    pmax = {1'b0, {(WIDTH-1){1'b1}}};
    nmax = {1'b1, {(WIDTH-1){1'b0}}};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 21;
    recv_idle = 66;

    // Directed words: every operation, the extremes, zero denominators,
    // a zero numerator, a negative factor and division by a zero fraction.
    send_word(OP_ADD, 1, 2, 1, 3);
    send_word(OP_SUB, 1, 2, 1, 2);
    send_word(OP_MUL, part_t'(-2), 4, 1, 1);
    send_word(OP_DIV, 3, 4, 0, 5);
    send_word(OP_DIV, 0, 0, 0, 0);
    send_word(OP_ADD, 5, 0, 7, 0);
    send_word(OP_MUL, 0, 7, 3, 0);
    send_word(OP_ADD, nmax, nmax, nmax, nmax);
    send_word(OP_SUB, nmax, pmax, pmax, nmax);
    send_word(OP_MUL, nmax, pmax, nmax, pmax);
    send_word(OP_DIV, pmax, nmax, pmax, nmax);
    send_word(OP_ADD, pmax, pmax, pmax, pmax);
    send_word(OP_SUB, pmax, 1, nmax, 1);
    send_word(OP_MUL, nmax, nmax, nmax, nmax);
    send_word(OP_DIV, nmax, nmax, 1, nmax);
    send_word(OP_DIV, pmax, 1, part_t'(-1), pmax);
    send_word(OP_ADD, part_t'(-1), part_t'(-1), 1, 1);
    send_word(OP_SUB, 0, part_t'(-5), 0, 3);
    send_word(OP_MUL, 6, part_t'(-9), 4, 10);
    send_word(OP_DIV, 6, 35, 10, 21);
    send_word(OP_ADD, 12, part_t'(-18), part_t'(-8), 30);

    // Random words in three idling phases, each with one full drain.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 21; recv_idle = 66; end
        1: begin send_idle = 66; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n == 50) drain_results();
        send_random();
      end
    end

    // Let the last results come out, then allow a short tail for stray words.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d add, %0d subtract, %0d multiply and %0d divide words.",
             words_per_op[0], words_per_op[1], words_per_op[2], words_per_op[3]);
    $display("Checked %0d reduced fractions, %0d of them flagged as divide by zero.",
             checked_count, flagged_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
